[design/bads_pkg.sv]
// Shared package of the block average downsampler.
// Holds widths, reset values, register indexes and luma coefficients.
// No dependencies.
`timescale 1ns / 1ps

package bads_pkg;

  // Default sizing of the top level.
  localparam int DEF_MAX_GRID_COLS = 64;
  localparam int DEF_MAX_FRAME_DIM = 1024;
  localparam int GRID_ROW_LIMIT    = 64;

  // Field widths.
  localparam int PIX_W      = 8;
  localparam int DIM_REG_W  = 11;
  localparam int GRID_REG_W = 7;
  localparam int POS_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Register indexes of the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GREYSCALE    = 3'd4;

  // Register reset values.
  localparam logic [DIM_REG_W-1:0]  RST_FRAME_WIDTH  = 11'd320;
  localparam logic [DIM_REG_W-1:0]  RST_FRAME_HEIGHT = 11'd240;
  localparam logic [GRID_REG_W-1:0] RST_GRID_COLS    = 7'd1;
  localparam logic [GRID_REG_W-1:0] RST_GRID_ROWS    = 7'd1;

  // Integer luma weights, scaled by one thousand.
  localparam int LUMA_W = 18;
  localparam logic [9:0] LUMA_R   = 10'd299;
  localparam logic [9:0] LUMA_G   = 10'd587;
  localparam logic [9:0] LUMA_B   = 10'd114;

  // Division by one thousand as a multiply by the rounded-up reciprocal
  // and a shift; exact for every weighted sum of 8-bit averages.
  localparam int LUMA_RECIP_W = 19;
  localparam int LUMA_SHIFT   = 28;
  localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 19'd268436;

  // Sequencer states.
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_LATW  = 10'b0000000010,
    ST_LATH  = 10'b0000000100,
    ST_SETUP = 10'b0000001000,
    ST_PIX   = 10'b0000010000,
    ST_RMW   = 10'b0000100000,
    ST_DIV   = 10'b0001000000,
    ST_GREY  = 10'b0010000000,
    ST_GDIV  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

endpackage

[design/bads_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module bads_div #(
  parameter int NW = 28,
  parameter int QW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [NW-1:0]    rem;
  logic [NW+QW-1:0] den_sh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             fits;

  assign fits = ({{QW{1'b0}}, rem} >= den_sh);

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: compare, subtract and shift in one quotient bit.
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= num;
      den_sh <= (NW + QW)'(den) << (QW - 1);
      quo    <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - NW'(den_sh);
      end
      den_sh <= den_sh >> 1;
      quo    <= {quo[QW-2:0], fits};
    end
  end

endmodule

[design/block_average_downsampler_top.sv]
// Top level of the block average downsampler.
// Uses bads_pkg and the iterative divider bads_div.
`timescale 1ns / 1ps

//  channel   | direction | contents
//  s_*       | in        | pixel request: red, green, blue
//  m_*       | out       | block result: column, row, averages, last of frame
//  cfg_*     | in        | register write: index, data
//
// A pixel inside a block passes through accept, memory read and write back;
// a pixel outside the grid skips the write back. A block's last pixel adds three
// divisions through the one shared divider, the luma product and shift in
// greyscale mode, and a load of the output register, which may have to wait.
// The first pixel of a frame adds two divisions for the block size and a
// setup step.
// Reset is synchronous; no clearing pass, each sum entry starts fresh at its
// block's first pixel. A stalled result waits in the output register while the
// next pixel is taken; a second result waits until that register drains.

module block_average_downsampler_top #(
  parameter int MAX_GRID_COLS = bads_pkg::DEF_MAX_GRID_COLS,
  parameter int MAX_FRAME_DIM = bads_pkg::DEF_MAX_FRAME_DIM
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [bads_pkg::IN_DATA_W-1:0]      s_tdata,   // pix_red, pix_green, pix_blue
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bads_pkg::OUT_DATA_W-1:0]     m_tdata,   // block_col, block_row, avg_red,
                                                         // avg_green, avg_blue, zero pad
  output logic                                m_tlast,   // frame_done
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bads_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bads_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import bads_pkg::*;

  localparam int DW = $clog2(MAX_FRAME_DIM + 1);
  localparam int AW = 2 * DW;
  localparam int SW = AW + PIX_W;
  localparam int IW = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
  localparam int CW = GRID_REG_W;
  localparam int PW = LUMA_W + LUMA_RECIP_W;

  // Configuration registers.
  logic [DIM_REG_W-1:0]  reg_width, reg_height;
  logic [GRID_REG_W-1:0] reg_cols, reg_rows;
  logic                  reg_grey;

  // Settings latched at frame start.
  logic [DW-1:0] cur_w, cur_h, bw, bh;
  logic [CW-1:0] cols_c, rows_c;
  logic          cur_grey;
  logic [AW-1:0] area;
  logic [CW+DW-1:0] row_span;

  // Position tracking.
  logic [DW-1:0] col, row, f, xo, yo;
  logic [CW-1:0] j, bi;

  // Captured pixel and per-pixel flags.
  logic [PIX_W-1:0] pix [3];
  logic             first_px, last_px, res_last;
  logic [IW-1:0]    addr;
  logic [CW-1:0]    res_col, res_row;

  // Sums, averages and luma.
  logic [SW-1:0]    sum_q [3];
  logic [PIX_W-1:0] avg [3];
  logic [1:0]       ch;
  logic [LUMA_W-1:0] luma;
  logic [PW-1:0]    luma_prod;

  // Memory of per-column sums.
  logic [3*SW-1:0] mem [MAX_GRID_COLS];
  logic [3*SW-1:0] rdata, wdata;
  logic            mem_rd, mem_we;
  logic [SW-1:0]   base [3];
  logic [SW-1:0]   nsum [3];

  // Divider handshake.
  logic          div_start, div_start_next, div_done;
  logic [SW-1:0] div_num, div_den;
  logic [DW-1:0] div_quo;

  state_t state;

  logic s_acc, in_blk, col_wrap, row_wrap;
  logic [DW-1:0] w_cl, h_cl;
  logic [CW-1:0] cols_cl, rows_cl;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid && s_tready;

  // Clamp the register values for the frame latch.
  assign w_cl = (reg_width == '0) ? DW'(1) :
                ({2'b0, reg_width} > 13'(MAX_FRAME_DIM)) ? DW'(MAX_FRAME_DIM) : DW'(reg_width);
  assign h_cl = (reg_height == '0) ? DW'(1) :
                ({2'b0, reg_height} > 13'(MAX_FRAME_DIM)) ? DW'(MAX_FRAME_DIM) : DW'(reg_height);
  assign cols_cl = ({2'b0, reg_cols} > 9'(MAX_GRID_COLS)) ? CW'(MAX_GRID_COLS) : reg_cols;
  assign rows_cl = ({2'b0, reg_rows} > 9'(GRID_ROW_LIMIT)) ? CW'(GRID_ROW_LIMIT) : reg_rows;

  // Pixel lies inside some block of the grid.
  assign in_blk = (bw != '0) && (bh != '0) && (j != cols_c) &&
                  ((CW + DW)'(f) < row_span);
  assign col_wrap = (col == cur_w - 1'b1);
  assign row_wrap = (row == cur_h - 1'b1);

  // Division starts: block size at frame start, then the three channel averages.
  assign div_start_next = (s_acc && col == '0 && row == '0) ||
                          (state == ST_LATW && div_done) ||
                          (state == ST_RMW && last_px) ||
                          (state == ST_DIV && div_done && ch != 2'd2);

  // Luma divided by one thousand through the reciprocal.
  assign luma_prod = PW'(luma) * PW'(LUMA_RECIP);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width  <= RST_FRAME_WIDTH;
      reg_height <= RST_FRAME_HEIGHT;
      reg_cols   <= RST_GRID_COLS;
      reg_rows   <= RST_GRID_ROWS;
      reg_grey   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  reg_width  <= cfg_data;
        REG_FRAME_HEIGHT: reg_height <= cfg_data;
        REG_GRID_COLS:    reg_cols   <= cfg_data[GRID_REG_W-1:0];
        REG_GRID_ROWS:    reg_rows   <= cfg_data[GRID_REG_W-1:0];
        REG_GREYSCALE:    reg_grey   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sum memory: one read port, one write port, registered read data.
  assign mem_rd = (state == ST_PIX) && in_blk;
  assign mem_we = (state == ST_RMW);

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rdata <= mem[IW'(j)];
    end
    if (mem_we) begin
      mem[addr] <= wdata;
    end
  end

  // Read, modify: a block's first pixel starts from zero.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      base[c] = first_px ? '0 : rdata[c*SW +: SW];
      nsum[c] = base[c] + SW'(pix[c]);
    end
    wdata = {nsum[2], nsum[1], nsum[0]};
  end

  bads_div #(
    .NW (SW),
    .QW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Divider start pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= div_start_next;
    end
  end

  // Result valid: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      col       <= '0;
      row       <= '0;
      cur_w     <= '0;
      cur_h     <= '0;
      cols_c    <= '0;
      rows_c    <= '0;
      cur_grey  <= 1'b0;
      bw        <= '0;
      bh        <= '0;
      ch        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            pix[0] <= s_tdata[7:0];
            pix[1] <= s_tdata[15:8];
            pix[2] <= s_tdata[23:16];
            if (col == '0 && row == '0) begin
              cur_w     <= w_cl;
              cur_h     <= h_cl;
              cols_c    <= cols_cl;
              rows_c    <= rows_cl;
              cur_grey  <= reg_grey;
              div_num   <= SW'(w_cl);
              div_den   <= SW'(cols_cl);
              state     <= ST_LATW;
            end else begin
              state <= ST_PIX;
            end
          end
        end
        ST_LATW: begin
          if (div_done) begin
            bw        <= (cols_c == '0) ? '0 : div_quo;
            div_num   <= SW'(cur_h);
            div_den   <= SW'(rows_c);
            state     <= ST_LATH;
          end
        end
        ST_LATH: begin
          if (div_done) begin
            bh    <= (rows_c == '0) ? '0 : div_quo;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          area     <= AW'(bw) * AW'(bh);
          row_span <= (CW + DW)'(rows_c) * (CW + DW)'(bh);
          f        <= cur_h - 1'b1;
          xo       <= '0;
          j        <= '0;
          yo       <= bh - 1'b1;
          bi       <= rows_c - 1'b1;
          state    <= ST_PIX;
        end
        ST_PIX: begin
          first_px <= (xo == '0) && (yo == bh - 1'b1);
          last_px  <= (xo == bw - 1'b1) && (yo == '0);
          res_last <= (bi == '0) && (j == cols_c - 1'b1);
          res_col  <= j;
          res_row  <= bi;
          addr     <= IW'(j);
          state    <= in_blk ? ST_RMW : ST_IDLE;
          // Advance to the next source position.
          if (col_wrap) begin
            col <= '0;
            row <= row_wrap ? '0 : row + 1'b1;
            xo  <= '0;
            j   <= '0;
            f   <= f - 1'b1;
            if ((CW + DW)'(f) < row_span) begin
              if (yo == '0) begin
                yo <= bh - 1'b1;
                bi <= bi - 1'b1;
              end else begin
                yo <= yo - 1'b1;
              end
            end
          end else begin
            col <= col + 1'b1;
            if (bw != '0 && j != cols_c) begin
              if (xo == bw - 1'b1) begin
                xo <= '0;
                j  <= j + 1'b1;
              end else begin
                xo <= xo + 1'b1;
              end
            end
          end
        end
        ST_RMW: begin
          for (int c = 0; c < 3; c++) begin
            sum_q[c] <= nsum[c];
          end
          if (last_px) begin
            ch        <= '0;
            div_num   <= nsum[0];
            div_den   <= SW'(area);
            state     <= ST_DIV;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            avg[ch] <= div_quo[PIX_W-1:0];
            if (ch == 2'd2) begin
              state <= cur_grey ? ST_GREY : ST_OUT;
            end else begin
              ch        <= ch + 1'b1;
              div_num   <= sum_q[ch + 1'b1];
            end
          end
        end
        ST_GREY: begin
          luma <= LUMA_W'(LUMA_R) * LUMA_W'(avg[0]) + LUMA_W'(LUMA_G) * LUMA_W'(avg[1]) +
                  LUMA_W'(LUMA_B) * LUMA_W'(avg[2]);
          state <= ST_GDIV;
        end
        ST_GDIV: begin
          avg[0] <= luma_prod[LUMA_SHIFT +: PIX_W];
          avg[1] <= luma_prod[LUMA_SHIFT +: PIX_W];
          avg[2] <= luma_prod[LUMA_SHIFT +: PIX_W];
          state  <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {4'b0, avg[2], avg[1], avg[0],
                         res_row[POS_W-1:0], res_col[POS_W-1:0]};
            m_tlast  <= res_last;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/bads_checker.sv]
// Port-level checks of the block average downsampler, bound to the top level.
// Depends on bads_pkg and block_average_downsampler_top.
`timescale 1ns / 1ps

module bads_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bads_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tlast,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  import bads_pkg::*;

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Each pixel request is worked on alone: no second request the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("pixel taken back to back");

  // A new result is only loaded while no pixel can be taken.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while idle");

  // The last block of a frame sits in the bottom grid row.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[11:6] == '0)
    else $error("frame end outside row zero");

  // Register writes are never held off.
  assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write stalled");

endmodule

bind block_average_downsampler_top bads_checker u_bads_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

[dv/tb_block_average_downsampler_top.sv]
// Self-checking testbench of the block average downsampler top level.
// Depends on bads_pkg and block_average_downsampler_top; predicts every block result.
`timescale 1ns / 1ps

module tb_block_average_downsampler_top;
  import bads_pkg::*;

  typedef struct packed {
    logic [5:0] col;
    logic [5:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       done;
  } block_avg_t;

  localparam int SETTLE_CYCLES = 400;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  block_average_downsampler_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Pending pixels, expected block averages and bookkeeping.
  logic [IN_DATA_W-1:0] pixel_q[$];
  block_avg_t           avg_q[$];
  int                   pixels_queued = 0;
  int                   pixels_taken = 0;
  int                   mismatches = 0;
  bit                   no_idle = 0;
  logic                 s_taken = 0;
  logic                 cfg_taken = 0;

  // Predictor state: written registers, frame latch, position and column sums.
  int unsigned reg_w = 320, reg_h = 240, reg_c = 1, reg_r = 1, reg_g = 0;
  int unsigned fr_w, fr_h, fr_c, fr_r, fr_g, blk_w, blk_h;
  int unsigned col_pos = 0, row_pos = 0;
  int unsigned sum_r[64], sum_g[64], sum_b[64];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    return (v > 1024) ? 1024 : v;
  endfunction

  // Follows one accepted pixel through the block grid.
  task automatic predict_pixel(input logic [IN_DATA_W-1:0] px);
    int unsigned x, f, j, xo, bi, yo, area, r, g, b, y;
    block_avg_t e;
    if (col_pos == 0 && row_pos == 0) begin
      fr_w = clamp_dim(reg_w);
      fr_h = clamp_dim(reg_h);
      fr_c = (reg_c > 64) ? 64 : reg_c;
      fr_r = (reg_r > 64) ? 64 : reg_r;
      fr_g = reg_g;
      blk_w = fr_c ? fr_w / fr_c : 0;
      blk_h = fr_r ? fr_h / fr_r : 0;
    end
    x = col_pos;
    f = fr_h - 1 - row_pos;
    if (blk_w != 0 && blk_h != 0 && x < fr_c * blk_w && f < fr_r * blk_h) begin
      j = x / blk_w;  xo = x % blk_w;
      bi = f / blk_h; yo = f % blk_h;
      if (xo == 0 && yo == blk_h - 1) begin
        sum_r[j] = 0; sum_g[j] = 0; sum_b[j] = 0;
      end
      sum_r[j] += px[7:0];
      sum_g[j] += px[15:8];
      sum_b[j] += px[23:16];
      if (xo == blk_w - 1 && yo == 0) begin
        area = blk_w * blk_h;
        r = sum_r[j] / area; g = sum_g[j] / area; b = sum_b[j] / area;
        if (fr_g != 0) begin
          y = (299 * r + 587 * g + 114 * b) / 1000;
          r = y; g = y; b = y;
        end
        e.col = j[5:0]; e.row = bi[5:0];
        e.red = r[7:0]; e.green = g[7:0]; e.blue = b[7:0];
        e.done = (bi == 0 && j == fr_c - 1);
        avg_q.push_back(e);
      end
    end
    col_pos++;
    if (col_pos >= fr_w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= fr_h) row_pos = 0;
    end
  endtask

  // Predict on accepted pixels and register writes, check accepted results.
  always @(posedge clk) begin
    block_avg_t e, got;
    s_taken <= s_tvalid && s_tready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  reg_w = cfg_data;
        REG_FRAME_HEIGHT: reg_h = cfg_data;
        REG_GRID_COLS:    reg_c = cfg_data[GRID_REG_W-1:0];
        REG_GRID_ROWS:    reg_r = cfg_data[GRID_REG_W-1:0];
        REG_GREYSCALE:    reg_g = cfg_data[0];
        default: ;
      endcase
    end
    if (!rst && s_tvalid && s_tready) begin
      predict_pixel(s_tdata);
      pixels_taken++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[5:0], m_tdata[11:6], m_tdata[19:12], m_tdata[27:20],
             m_tdata[35:28], m_tlast};
      if (avg_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected block result %h", got);
      end else begin
        e = avg_q.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"block mismatch: expected col %0d row %0d rgb %0d/%0d/%0d last %0d,",
                      " got col %0d row %0d rgb %0d/%0d/%0d last %0d"},
                     e.col, e.row, e.red, e.green, e.blue, e.done,
                     got.col, got.row, got.red, got.green, got.blue, got.done);
        end
      end
    end
  end

  // Pixel driver: holds a request until taken, idles now and then.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (s_tvalid && !s_taken) begin
      s_tvalid <= 1;
    end else if (pixel_q.size() > 0 && (no_idle || $urandom_range(99) >= 16)) begin
      s_tvalid <= 1;
      s_tdata <= pixel_q.pop_front();
    end else begin
      s_tvalid <= 0;
    end
  end

  // Result receiver stalls now and then.
  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : (no_idle || $urandom_range(99) >= 16);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 0;
  endtask

  // Wait until all pixels are in and all blocks are out, then let the divider settle.
  task automatic drain();
    while (pixels_taken != pixels_queued || avg_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all registers and queues whole frames; pattern 0 random, 1 extremes.
  task automatic run_frames(input int unsigned w, h, c, r, g, frames, pattern);
    int unsigned n;
    logic [23:0] px;
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_GRID_COLS, c);
    write_reg(REG_GRID_ROWS, r);
    write_reg(REG_GREYSCALE, g);
    n = clamp_dim(w) * clamp_dim(h) * frames;
    for (int i = 0; i < n; i++) begin
      if (pattern == 1) px = {24{i[0]}} ^ {8'h00, {8{i[1]}}, 8'h00};
      else if ($urandom_range(9) == 0) px = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
      else px = 24'($urandom);
      pixel_q.push_back(px);
    end
    pixels_queued += n;
    drain();
  endtask

  initial begin
    int unsigned w, h;
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    m_tready = 0;
    cfg_valid = 0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed frames: full-scale pixels, zero and oversized settings, empty grids.
    run_frames(4, 4, 2, 2, 0, 1, 1);
    run_frames(0, 0, 1, 1, 1, 2, 1);
    run_frames(3, 2, 0, 1, 0, 1, 0);
    run_frames(3, 2, 5, 1, 1, 1, 0);
    run_frames(7, 5, 2, 2, 1, 1, 1);
    no_idle = 1;
    run_frames(2047, 1, 127, 1, 0, 1, 0);
    no_idle = 0;
    run_frames(2, 70, 1, 127, 1, 1, 0);

    // Random frames, mostly small, with a stretch without idling.
    for (int p = 0; pixels_queued < 1900; p++) begin
      no_idle = (p >= 10 && p < 20);
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 16);
      run_frames(w, h,
                 ($urandom_range(7) == 0) ? $urandom_range(0, 20) : $urandom_range(1, w),
                 ($urandom_range(7) == 0) ? $urandom_range(0, 20) : $urandom_range(1, h),
                 $urandom_range(1), $urandom_range(1, 3), 0);
    end
    no_idle = 0;

    if (mismatches == 0) begin
      $display("block_average_downsampler_top regression: pass");
    end else begin
      $display("block_average_downsampler_top regression: fail");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("block_average_downsampler_top regression: fail");
    $finish;
  end

endmodule

[sim.f]
design/bads_pkg.sv
design/bads_div.sv
design/block_average_downsampler_top.sv
design/bads_checker.sv
dv/tb_block_average_downsampler_top.sv
